// ----- sv/spt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spirometry test sequencer package
// Shared widths, phase and register codes, sequencer states and the request
// and response types of the shared add/subtract unit.
// ----------------------------------------------------------------------------
package spt_pkg;

	localparam int VPP_W     = 12;
	localparam int START_W   = 10;
	localparam int WIN_W     = 6;
	localparam int TOT_W     = 16;
	localparam int VOL_W     = 28;
	localparam int RATIO_W   = 10;
	localparam int PHASE_W   = 2;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CNT_W     = 4;

	// phase codes as seen on the result channel
	localparam logic [PHASE_W-1:0] PHASE_IDLE   = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_ARMED  = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_EXHALE = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VOLUME_PER_PULSE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_PULSES     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FEV1_WINDOWS     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEST_WINDOWS     = 2'd3;

	localparam logic [VPP_W-1:0]   RST_VOLUME_PER_PULSE = 12'd569;
	localparam logic [START_W-1:0] RST_START_PULSES     = 10'd1;
	localparam logic [WIN_W-1:0]   RST_FEV1_WINDOWS     = 6'd4;
	localparam logic [WIN_W-1:0]   RST_TEST_WINDOWS     = 6'd24;

	localparam logic [WIN_W-1:0] WIN_MAX     = 6'd63;
	localparam logic [TOT_W-1:0] TOT_MAX     = 16'hFFFF;
	localparam logic [VPP_W-1:0] RATIO_SCALE = 12'd1000;

	// last iteration index of a multiply and of the ratio divide
	localparam logic [CNT_W-1:0] MUL_LAST = 4'd11;
	localparam logic [CNT_W-1:0] DIV_LAST = 4'd9;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_MUL_VOL,
		SEQ_MUL_FEV,
		SEQ_MUL_K,
		SEQ_DIV,
		SEQ_OUT
	} seq_state_t;

	typedef struct packed {
		logic [VOL_W-1:0] a;
		logic [VOL_W-1:0] b;
		logic             sub;
	} alu_req_t;

	typedef struct packed {
		logic [VOL_W-1:0] sum;
		logic             carry;
	} alu_rsp_t;

endpackage

// ----- sv/spt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spirometry test sequencer channels
// Valid/ready channels for measurement windows and for test results.
// ----------------------------------------------------------------------------
interface spt_window_if #(
	parameter int PULSE_COUNT_BITS = 10
) ();
	logic                        valid;
	logic                        ready;
	logic                        button_pressed;
	logic [PULSE_COUNT_BITS-1:0] pulse_count;

	modport source (output valid, output button_pressed, output pulse_count, input ready);
	modport sink   (input valid, input button_pressed, input pulse_count, output ready);
endinterface

interface spt_result_if ();
	logic        valid;
	logic        ready;
	logic [1:0]  phase;
	logic [5:0]  elapsed_windows;
	logic [27:0] volume_q8;
	logic [27:0] fev1_q8;
	logic [9:0]  ratio_permille;
	logic        test_done;
	logic        exhale_started;

	modport source (
		output valid, output phase, output elapsed_windows, output volume_q8,
		output fev1_q8, output ratio_permille, output test_done, output exhale_started,
		input ready
	);
	modport sink (
		input valid, input phase, input elapsed_windows, input volume_q8,
		input fev1_q8, input ratio_permille, input test_done, input exhale_started,
		output ready
	);
endinterface

// ----- sv/spt_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spirometry shared add/subtract unit
// One 28-bit adder used for shift-add multiplies and for restoring divide
// steps; carry out on a subtract means a >= b.
// ----------------------------------------------------------------------------
module spt_alu (
	input  spt_pkg::alu_req_t req,
	output spt_pkg::alu_rsp_t rsp
);
	import spt_pkg::*;

	logic [VOL_W:0] sum_ext;
	logic [VOL_W-1:0] b_eff;

	assign b_eff   = req.sub ? ~req.b : req.b;
	assign sum_ext = {1'b0, req.a} + {1'b0, b_eff} + (VOL_W+1)'(req.sub);

	assign rsp.sum   = sum_ext[VOL_W-1:0];
	assign rsp.carry = sum_ext[VOL_W];

endmodule

// ----- sv/spirometry_test_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spirometry test sequencer
// Tracks idle/armed/exhale phases over measurement windows and reports
// volumes and the FEV1/FVC ratio through one shared add/subtract unit.
// ----------------------------------------------------------------------------
// One window request is taken when the sequencer is idle; window.ready stays
// low until its result has been handed to the output register. The phase and
// pulse totals update in the cycle of the request. The two volumes are then
// formed by 12-step shift-add multiplies on the shared 28-bit adder. A window
// that ends a test with a nonzero total also runs a 12-step multiply by 1000
// and a 10-step restoring divide on the same adder. A result waiting in the
// output register does not block the next request, only the next load.
// Start-pulse and window settings take effect on the next window; the volume
// per pulse is also read again when the FEV1 multiply is set up.
module spirometry_test_sequencer #(
	parameter int PULSE_COUNT_BITS = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [spt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [spt_pkg::CFG_W-1:0]        cfg_data,
	spt_window_if.sink                       window,
	spt_result_if.source                     result
);
	import spt_pkg::*;

	localparam int CMP_W = (PULSE_COUNT_BITS > START_W) ? PULSE_COUNT_BITS : START_W;

	// configuration
	logic [VPP_W-1:0]   vpp_q;
	logic [START_W-1:0] start_q;
	logic [WIN_W-1:0]   fev1w_q;
	logic [WIN_W-1:0]   testw_q;

	// test state
	logic [PHASE_W-1:0] phase_q;
	logic [WIN_W-1:0]   win_q;
	logic [TOT_W-1:0]   total_q;
	logic [TOT_W-1:0]   fev1p_q;
	logic               latched_q;

	// sequencer
	seq_state_t       seq_q, seq_d;
	logic [CNT_W-1:0] cnt_q;
	logic             cnt_clr;
	logic             out_valid_q;
	logic             load_out;
	logic             accept;

	// values captured for the report of the current window
	logic [PHASE_W-1:0] rep_phase_q;
	logic [WIN_W-1:0]   rep_win_q;
	logic [TOT_W-1:0]   rep_tot_q;
	logic [TOT_W-1:0]   rep_fev_q;
	logic               rep_done_q;
	logic               rep_start_q;

	// datapath
	logic [VOL_W-1:0] acc_q;
	logic [VOL_W-1:0] mcand_q;
	logic [VPP_W-1:0] mplr_q;
	logic [VOL_W-1:0] vol_q;
	logic [VOL_W-1:0] fevv_q;
	logic [VOL_W-1:0] mul_next;
	logic [TOT_W:0]   div_rem;
	alu_req_t         alu_req;
	alu_rsp_t         alu_rsp;

	// result register
	logic [PHASE_W-1:0] res_phase_q;
	logic [WIN_W-1:0]   res_win_q;
	logic [VOL_W-1:0]   res_vol_q;
	logic [VOL_W-1:0]   res_fev_q;
	logic [RATIO_W-1:0] res_ratio_q;
	logic               res_done_q;
	logic               res_start_q;

	// window update
	logic [PULSE_COUNT_BITS-1:0] pulses_w;
	logic [WIN_W-1:0]            win_inc;
	logic [TOT_W:0]              tot_sum;
	logic [TOT_W-1:0]            tot_sat;
	logic [PHASE_W-1:0]          upd_phase;
	logic [WIN_W-1:0]            upd_win;
	logic [TOT_W-1:0]            upd_tot;
	logic [TOT_W-1:0]            upd_fev;
	logic                        upd_lat;
	logic                        upd_done;
	logic                        upd_start;

	assign accept       = window.valid && window.ready;
	assign window.ready = (seq_q == SEQ_IDLE);

	assign pulses_w = window.pulse_count;
	assign win_inc  = (win_q == WIN_MAX) ? win_q : win_q + 1'b1;
	assign tot_sum  = {1'b0, total_q} + (TOT_W+1)'(pulses_w);
	assign tot_sat  = tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];

	always_comb begin
		upd_phase = phase_q;
		upd_win   = win_q;
		upd_tot   = total_q;
		upd_fev   = fev1p_q;
		upd_lat   = latched_q;
		upd_done  = 1'b0;
		upd_start = 1'b0;
		case (phase_q)
			PHASE_EXHALE: begin
				upd_win = win_inc;
				if (win_inc >= testw_q) begin
					upd_done = 1'b1;
				end else begin
					upd_tot = tot_sat;
					if (!latched_q && (win_inc >= fev1w_q)) begin
						upd_fev = tot_sat;
						upd_lat = 1'b1;
					end
				end
			end
			PHASE_ARMED: begin
				if (CMP_W'(pulses_w) >= CMP_W'(start_q)) begin
					upd_phase = PHASE_EXHALE;
					upd_win   = '0;
					upd_tot   = '0;
					upd_fev   = '0;
					upd_lat   = 1'b0;
					upd_start = 1'b1;
				end
			end
			default: begin
				// idle or an unused phase code: arm on a button press, else go to idle
				upd_phase = window.button_pressed ? PHASE_ARMED : PHASE_IDLE;
			end
		endcase
	end

	// configuration and test state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vpp_q     <= RST_VOLUME_PER_PULSE;
			start_q   <= RST_START_PULSES;
			fev1w_q   <= RST_FEV1_WINDOWS;
			testw_q   <= RST_TEST_WINDOWS;
			phase_q   <= PHASE_IDLE;
			win_q     <= '0;
			total_q   <= '0;
			fev1p_q   <= '0;
			latched_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_VOLUME_PER_PULSE: vpp_q   <= cfg_data[VPP_W-1:0];
					REG_START_PULSES:     start_q <= cfg_data[START_W-1:0];
					REG_FEV1_WINDOWS:     fev1w_q <= cfg_data[WIN_W-1:0];
					REG_TEST_WINDOWS:     testw_q <= cfg_data[WIN_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				if (upd_done) begin
					phase_q   <= PHASE_IDLE;
					win_q     <= '0;
					total_q   <= '0;
					fev1p_q   <= '0;
					latched_q <= 1'b0;
				end else begin
					phase_q   <= upd_phase;
					win_q     <= upd_win;
					total_q   <= upd_tot;
					fev1p_q   <= upd_fev;
					latched_q <= upd_lat;
				end
			end
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= SEQ_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			rep_done_q  <= 1'b0;
		end else begin
			seq_q <= seq_d;
			cnt_q <= cnt_clr ? '0 : cnt_q + 1'b1;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				rep_done_q <= upd_done;
			end
		end
	end

	always_comb begin
		seq_d    = seq_q;
		cnt_clr  = 1'b1;
		load_out = 1'b0;
		case (seq_q)
			SEQ_IDLE: begin
				if (accept) begin
					seq_d = SEQ_MUL_VOL;
				end
			end
			SEQ_MUL_VOL: begin
				cnt_clr = (cnt_q == MUL_LAST);
				if (cnt_q == MUL_LAST) begin
					seq_d = SEQ_MUL_FEV;
				end
			end
			SEQ_MUL_FEV: begin
				cnt_clr = (cnt_q == MUL_LAST);
				if (cnt_q == MUL_LAST) begin
					// ratio only on the final window with a nonzero total
					seq_d = (rep_done_q && (rep_tot_q != '0)) ? SEQ_MUL_K : SEQ_OUT;
				end
			end
			SEQ_MUL_K: begin
				cnt_clr = (cnt_q == MUL_LAST);
				if (cnt_q == MUL_LAST) begin
					seq_d = SEQ_DIV;
				end
			end
			SEQ_DIV: begin
				cnt_clr = (cnt_q == DIV_LAST);
				if (cnt_q == DIV_LAST) begin
					seq_d = SEQ_OUT;
				end
			end
			SEQ_OUT: begin
				if (!out_valid_q || result.ready) begin
					load_out = 1'b1;
					seq_d    = SEQ_IDLE;
				end
			end
			default: begin
				seq_d = SEQ_IDLE;
			end
		endcase
	end

	// shared adder: partial product add, or trial subtract of the divisor
	assign div_rem = {acc_q[RATIO_W+TOT_W-1:RATIO_W], acc_q[RATIO_W-1]};

	always_comb begin
		if (seq_q == SEQ_DIV) begin
			alu_req.a   = VOL_W'(div_rem);
			alu_req.b   = VOL_W'(rep_tot_q);
			alu_req.sub = 1'b1;
		end else begin
			alu_req.a   = acc_q;
			alu_req.b   = mcand_q;
			alu_req.sub = 1'b0;
		end
	end

	spt_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign mul_next = mplr_q[0] ? alu_rsp.sum : acc_q;

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			rep_phase_q <= upd_done ? PHASE_IDLE : upd_phase;
			rep_win_q   <= upd_win;
			rep_tot_q   <= upd_tot;
			rep_fev_q   <= upd_fev;
			rep_start_q <= upd_start;
			acc_q       <= '0;
			mcand_q     <= VOL_W'(upd_tot);
			mplr_q      <= vpp_q;
		end
		case (seq_q)
			SEQ_MUL_VOL, SEQ_MUL_FEV, SEQ_MUL_K: begin
				if (cnt_q != MUL_LAST) begin
					acc_q   <= mul_next;
					mcand_q <= {mcand_q[VOL_W-2:0], 1'b0};
					mplr_q  <= {1'b0, mplr_q[VPP_W-1:1]};
				end else if (seq_q == SEQ_MUL_VOL) begin
					// set up the next multiply: FEV1 volume
					vol_q   <= mul_next;
					acc_q   <= '0;
					mcand_q <= VOL_W'(rep_fev_q);
					mplr_q  <= vpp_q;
				end else if (seq_q == SEQ_MUL_FEV) begin
					// set up FEV1 * 1000 for the ratio
					fevv_q  <= mul_next;
					acc_q   <= '0;
					mcand_q <= VOL_W'(rep_fev_q);
					mplr_q  <= RATIO_SCALE;
				end else begin
					acc_q <= mul_next;
				end
			end
			SEQ_DIV: begin
				// shift the quotient bit in at the bottom
				acc_q <= {{(VOL_W-TOT_W-RATIO_W){1'b0}},
					(alu_rsp.carry ? alu_rsp.sum[TOT_W-1:0] : div_rem[TOT_W-1:0]),
					acc_q[RATIO_W-2:0], alu_rsp.carry};
			end
			default: ;
		endcase
		if (load_out) begin
			res_phase_q <= rep_phase_q;
			res_win_q   <= rep_win_q;
			res_vol_q   <= vol_q;
			res_fev_q   <= fevv_q;
			res_ratio_q <= (rep_done_q && (rep_tot_q != '0)) ? acc_q[RATIO_W-1:0] : '0;
			res_done_q  <= rep_done_q;
			res_start_q <= rep_start_q;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.phase           = res_phase_q;
	assign result.elapsed_windows = res_win_q;
	assign result.volume_q8       = res_vol_q;
	assign result.fev1_q8         = res_fev_q;
	assign result.ratio_permille  = res_ratio_q;
	assign result.test_done       = res_done_q;
	assign result.exhale_started  = res_start_q;

	// the latched FEV1 count never exceeds the running total
	a_fev1_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		fev1p_q <= total_q)
		else $error("FEV1 pulse count exceeds total");

	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.ratio_permille <= 10'd1000)
		else $error("ratio out of range");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.test_done |-> result.phase == PHASE_IDLE
			&& !result.exhale_started)
		else $error("finished test not reported as idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> seq_q == SEQ_MUL_VOL && !window.ready)
		else $error("sequencer did not start on request");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !out_valid_q || result.ready)
		else $error("result register overwritten");

endmodule
